### hw/rtl/cpam_pkg.sv
// Shared types, constants and helpers for the CIDR and port ACL matcher.
package cpam_pkg;

    localparam int RULE_SLOTS = 256;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

    localparam logic [31:0] LOOPBACK_ADDR = 32'h7f00_0001;
    localparam logic [31:0] FULL_MASK     = 32'hFFFF_FFFF;
    localparam logic [5:0]  MAX_PREFIX    = 6'd32;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_CHECK = 1'b1
    } req_type_t;

    typedef enum logic {
        TBL_DENY  = 1'b0,
        TBL_ALLOW = 1'b1
    } table_sel_t;

    typedef enum logic [1:0] {
        CAUSE_LOOPBACK     = 2'd0,
        CAUSE_DENY_HIT     = 2'd1,
        CAUSE_ALLOW_HIT    = 2'd2,
        CAUSE_DEFAULT_DENY = 2'd3
    } cause_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DENY,
        ST_ALLOW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [5:0]  prefix;
    } rule_t;

    typedef struct packed {
        logic term;
        logic hit;
    } match_t;

    // Map the 8-bit slot field onto a table address.
    function automatic logic [SLOT_W-1:0] slot_to_addr(input logic [7:0] slot);
        logic [SLOT_W+7:0] wide;
        wide = {{SLOT_W{1'b0}}, slot};
        return wide[SLOT_W-1:0];
    endfunction

    // True when the slot field names an existing table entry.
    function automatic logic slot_in_range(input logic [7:0] slot);
        logic [SLOT_W+7:0] wide;
        wide = {{SLOT_W{1'b0}}, slot};
        return wide < (SLOT_W + 8)'(RULE_SLOTS);
    endfunction

    // Low 8 bits of a table address, as reported in hit_slot.
    function automatic logic [7:0] addr_to_slot(input logic [SLOT_W-1:0] addr);
        logic [SLOT_W+7:0] wide;
        wide = {8'd0, addr};
        return wide[7:0];
    endfunction

endpackage

### hw/rtl/cpam_rule_ram.sv
// Single-port-write, registered-read rule table memory.
module cpam_rule_ram
    import cpam_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  rule_t             wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output rule_t             rd_data
);

    rule_t mem [RULE_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/cpam_rule_match.sv
// Compare one stored rule against a destination address and port.
module cpam_rule_match
    import cpam_pkg::*;
(
    input  rule_t       rule,
    input  logic [31:0] dest_address,
    input  logic [15:0] dest_port,
    output match_t      result
);

    logic [31:0] mask;
    logic        exact;
    logic        addr_ok;
    logic        port_ok;

    always_comb begin
        exact   = (rule.prefix == 6'd0) || (rule.prefix >= MAX_PREFIX);
        // top prefix bits set, valid for prefixes 1 through 31
        mask    = ~(FULL_MASK >> rule.prefix);
        if (rule.address == 32'd0) begin
            addr_ok = 1'b1;
        end else if (exact) begin
            addr_ok = (dest_address == rule.address);
        end else begin
            addr_ok = ((dest_address & mask) == (rule.address & mask));
        end
        port_ok     = (rule.port == 16'd0) || (rule.port == dest_port);
        result.term = (rule.address == 32'd0) && (rule.port == 16'd0);
        result.hit  = addr_ok && port_ok;
    end

endmodule

### hw/rtl/cidr_port_acl_match.sv
// Top level of the first-match CIDR and port ACL: control, scan and result register.
//
//  channel | dir | ports                     | content
//  --------+-----+---------------------------+-----------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata | rule write or connection check
//          |     | s_tuser                   | req_type, table_select
//  m_      | out | m_tvalid m_tready m_tdata | verdict, one per check
//
// A write goes into its table as it is accepted. A check of the loopback address goes
// from idle straight to the done state; any other check reads the deny table, then,
// unless a deny rule hits, the allow table, one entry per cycle through the registered
// read port, each scan ending at a hit, a terminator entry or the end of the table.
// After reset both tables are cleared, all RULE_SLOTS (256) entries, before s_tready rises.
// A finished verdict waits in the output register; a further check may start
// meanwhile and holds in its last state until that register is free.
module cidr_port_acl_match
    import cpam_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] rule_slot, [39:8] rule_address, [55:40] rule_port,
    // [61:56] rule_prefix, [93:62] dest_address, [109:94] dest_port, [111:110] zero
    input  logic [111:0] s_tdata,
    // [0] req_type, [1] table_select
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] allowed, [2:1] verdict_cause, [10:3] hit_slot, [15:11] zero
    output logic [15:0]  m_tdata
);

    // input fields
    logic        in_req_type;
    logic        in_table_select;
    logic [7:0]  in_rule_slot;
    logic [31:0] in_rule_address;
    logic [15:0] in_rule_port;
    logic [5:0]  in_rule_prefix;
    logic [31:0] in_dest_address;
    logic [15:0] in_dest_port;

    assign in_req_type     = s_tuser[0];
    assign in_table_select = s_tuser[1];
    assign in_rule_slot    = s_tdata[7:0];
    assign in_rule_address = s_tdata[39:8];
    assign in_rule_port    = s_tdata[55:40];
    assign in_rule_prefix  = s_tdata[61:56];
    assign in_dest_address = s_tdata[93:62];
    assign in_dest_port    = s_tdata[109:94];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [31:0]       dest_addr_reg, dest_addr_next;
    logic [15:0]       dest_port_reg, dest_port_next;
    logic              verd_allowed_reg, verd_allowed_next;
    cause_t            verd_cause_reg, verd_cause_next;
    logic [7:0]        verd_slot_reg, verd_slot_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_allowed_reg, out_allowed_next;
    cause_t            out_cause_reg, out_cause_next;
    logic [7:0]        out_slot_reg, out_slot_next;

    logic              in_fire;
    logic              is_check;
    logic              is_loopback;
    logic              idx_end;
    logic              clear_last;
    logic              out_free;
    logic              scan_stop;

    logic              wr_en_deny;
    logic              wr_en_allow;
    logic [SLOT_W-1:0] wr_addr;
    rule_t             wr_data;
    logic              rd_en_deny;
    logic              rd_en_allow;
    logic [SLOT_W-1:0] rd_addr;
    rule_t             deny_rd_data;
    rule_t             allow_rd_data;
    rule_t             cur_entry;
    match_t            cur_match;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign is_check    = (req_type_t'(in_req_type) == REQ_CHECK);
    assign is_loopback = (in_dest_address == LOOPBACK_ADDR);
    assign idx_end     = (idx_reg == CNT_W'(RULE_SLOTS));
    assign clear_last  = (idx_reg == CNT_W'(RULE_SLOTS - 1));
    assign out_free    = !m_tvalid_reg || m_tready;
    assign cur_entry   = (state_reg == ST_ALLOW) ? allow_rd_data : deny_rd_data;
    assign scan_stop   = pend_reg && (cur_match.term || cur_match.hit || idx_end);
    assign rd_addr     = idx_reg[SLOT_W-1:0];

    cpam_rule_ram u_deny_ram (
        .aclk    (aclk),
        .wr_en   (wr_en_deny),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en_deny),
        .rd_addr (rd_addr),
        .rd_data (deny_rd_data)
    );

    cpam_rule_ram u_allow_ram (
        .aclk    (aclk),
        .wr_en   (wr_en_allow),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en_allow),
        .rd_addr (rd_addr),
        .rd_data (allow_rd_data)
    );

    cpam_rule_match u_match (
        .rule         (cur_entry),
        .dest_address (dest_addr_reg),
        .dest_port    (dest_port_reg),
        .result       (cur_match)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && is_check) begin
                    state_next = is_loopback ? ST_DONE : ST_DENY;
                end
            end
            ST_DENY: begin
                if (scan_stop) begin
                    state_next = (cur_match.hit && !cur_match.term) ? ST_DONE : ST_ALLOW;
                end
            end
            ST_ALLOW: begin
                if (scan_stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory control, scan pointer, verdict and output register
    always_comb begin
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        pend_slot_next    = pend_slot_reg;
        dest_addr_next    = dest_addr_reg;
        dest_port_next    = dest_port_reg;
        verd_allowed_next = verd_allowed_reg;
        verd_cause_next   = verd_cause_reg;
        verd_slot_next    = verd_slot_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        out_allowed_next  = out_allowed_reg;
        out_cause_next    = out_cause_reg;
        out_slot_next     = out_slot_reg;
        wr_en_deny        = 1'b0;
        wr_en_allow       = 1'b0;
        wr_addr           = slot_to_addr(in_rule_slot);
        wr_data.address   = in_rule_address;
        wr_data.port      = in_rule_port;
        wr_data.prefix    = (in_rule_prefix > MAX_PREFIX) ? MAX_PREFIX : in_rule_prefix;
        rd_en_deny        = 1'b0;
        rd_en_allow       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                wr_en_deny  = 1'b1;
                wr_en_allow = 1'b1;
                wr_addr     = idx_reg[SLOT_W-1:0];
                wr_data     = '0;
                idx_next    = clear_last ? '0 : idx_reg + CNT_W'(1);
            end
            ST_IDLE: begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (in_fire) begin
                    if (is_check) begin
                        dest_addr_next  = in_dest_address;
                        dest_port_next  = in_dest_port;
                        verd_slot_next  = 8'd0;
                        if (is_loopback) begin
                            verd_allowed_next = 1'b1;
                            verd_cause_next   = CAUSE_LOOPBACK;
                        end else begin
                            verd_allowed_next = 1'b0;
                            verd_cause_next   = CAUSE_DEFAULT_DENY;
                        end
                    end else if (slot_in_range(in_rule_slot)) begin
                        wr_en_deny  = (table_sel_t'(in_table_select) == TBL_DENY);
                        wr_en_allow = (table_sel_t'(in_table_select) == TBL_ALLOW);
                    end
                end
            end
            ST_DENY, ST_ALLOW: begin
                if (scan_stop) begin
                    // restart the pointer for the next table or the next check
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (cur_match.hit && !cur_match.term) begin
                        verd_slot_next = addr_to_slot(pend_slot_reg);
                        if (state_reg == ST_DENY) begin
                            verd_allowed_next = 1'b0;
                            verd_cause_next   = CAUSE_DENY_HIT;
                        end else begin
                            verd_allowed_next = 1'b1;
                            verd_cause_next   = CAUSE_ALLOW_HIT;
                        end
                    end
                end else if (!idx_end) begin
                    rd_en_deny     = (state_reg == ST_DENY);
                    rd_en_allow    = (state_reg == ST_ALLOW);
                    idx_next       = idx_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_slot_next = idx_reg[SLOT_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    out_allowed_next = verd_allowed_reg;
                    out_cause_next   = verd_cause_reg;
                    out_slot_next    = verd_slot_reg;
                end
            end
            default: begin
                idx_next  = '0;
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg    <= pend_slot_next;
        dest_addr_reg    <= dest_addr_next;
        dest_port_reg    <= dest_port_next;
        verd_allowed_reg <= verd_allowed_next;
        verd_cause_reg   <= verd_cause_next;
        verd_slot_reg    <= verd_slot_next;
        out_allowed_reg  <= out_allowed_next;
        out_cause_reg    <= out_cause_next;
        out_slot_reg     <= out_slot_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_slot_reg, out_cause_reg, out_allowed_reg};

endmodule

### tb/acl_verdict_checker.sv
`timescale 1ns / 100ps
// Verdict checker for the ACL matcher: mirrors both rule tables and scores every verdict.
module acl_verdict_checker
    import cpam_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    output int           mismatches,
    output int           pending
);

    typedef struct packed {
        logic       allowed;
        cause_t     cause;
        logic [7:0] slot;
    } verdict_t;

    // Indexed by table_sel_t: deny table first, allow table second.
    rule_t    rules [2][RULE_SLOTS];
    verdict_t awaited_verdicts [$];
    int       error_tally = 0;

    function automatic logic rule_covers(input rule_t r, input logic [31:0] addr,
                                         input logic [15:0] port);
        logic [31:0] keep;
        logic        addr_ok;
        if (r.address == '0) begin
            addr_ok = 1'b1;
        end else if (r.prefix == '0 || r.prefix >= MAX_PREFIX) begin
            addr_ok = (addr == r.address);
        end else begin
            keep    = FULL_MASK << (32 - r.prefix);
            addr_ok = ((addr ^ r.address) & keep) == '0;
        end
        return addr_ok && (r.port == '0 || r.port == port);
    endfunction

    // Slot of the first covering rule, or -1 if none is found before an empty entry or the table's end.
    function automatic int first_hit(input table_sel_t tbl, input logic [31:0] addr,
                                     input logic [15:0] port);
        rule_t r;
        for (int i = 0; i < RULE_SLOTS; i++) begin
            r = rules[tbl][i];
            if (r.address == '0 && r.port == '0)
                return -1;
            if (rule_covers(r, addr, port))
                return i;
        end
        return -1;
    endfunction

    function automatic verdict_t judge_connection(input logic [31:0] addr,
                                                  input logic [15:0] port);
        verdict_t v;
        int       hit;
        v.allowed = 1'b0;
        v.cause   = CAUSE_DEFAULT_DENY;
        v.slot    = '0;
        if (addr == LOOPBACK_ADDR) begin
            v.allowed = 1'b1;
            v.cause   = CAUSE_LOOPBACK;
        end else begin
            hit = first_hit(TBL_DENY, addr, port);
            if (hit >= 0) begin
                v.cause = CAUSE_DENY_HIT;
                v.slot  = 8'(hit);
            end else begin
                hit = first_hit(TBL_ALLOW, addr, port);
                if (hit >= 0) begin
                    v.allowed = 1'b1;
                    v.cause   = CAUSE_ALLOW_HIT;
                    v.slot    = 8'(hit);
                end
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t   seen;
        verdict_t   want;
        logic [7:0] slot;
        logic [5:0] prefix;
        if (!aresetn) begin
            foreach (rules[t, i])
                rules[t][i] = '0;
            awaited_verdicts.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (req_type_t'(s_tuser[0]) == REQ_WRITE) begin
                    slot   = s_tdata[7:0];
                    prefix = s_tdata[61:56];
                    // saturate long prefixes to an exact match
                    if (int'(slot) < RULE_SLOTS)
                        rules[s_tuser[1]][slot] = {s_tdata[39:8], s_tdata[55:40],
                                                   (prefix > MAX_PREFIX) ? MAX_PREFIX : prefix};
                end else begin
                    awaited_verdicts.push_back(judge_connection(s_tdata[93:62],
                                                                s_tdata[109:94]));
                end
            end
            if (m_tvalid && m_tready) begin
                seen.allowed = m_tdata[0];
                seen.cause   = cause_t'(m_tdata[2:1]);
                seen.slot    = m_tdata[10:3];
                if (awaited_verdicts.size() == 0) begin
                    $error("verdict with no check outstanding: m_tdata %h", m_tdata);
                    error_tally++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (seen.allowed !== want.allowed) begin
                        $error("allowed: expected %0d, got %0d", want.allowed, seen.allowed);
                        error_tally++;
                    end
                    if (seen.cause !== want.cause) begin
                        $error("verdict_cause: expected %0d, got %0d", want.cause, seen.cause);
                        error_tally++;
                    end
                    if (seen.slot !== want.slot) begin
                        $error("hit_slot: expected %0d, got %0d", want.slot, seen.slot);
                        error_tally++;
                    end
                end
            end
        end
        mismatches <= error_tally;
        pending    <= awaited_verdicts.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the ACL matcher: clock, reset, rule and check traffic, final verdict.
module testbench;
    import cpam_pkg::*;

    localparam int     RANDOM_ITEMS  = 1135;
    localparam int     MAX_GAP       = 16;
    localparam int     SETTLE_CYCLES = 2 * RULE_SLOTS + 8;
    localparam longint CYCLE_LIMIT   = 3_500_000;

    typedef struct {
        req_type_t   kind;
        table_sel_t  tbl;
        logic [7:0]  slot;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [5:0]  rprefix;
        logic [31:0] daddr;
        logic [15:0] dport;
    } acl_req_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;

    int     mismatches;
    int     pending;
    longint cycles    = 0;
    bit     tx_burst  = 1'b0;
    bit     rx_burst  = 1'b0;

    // What the stimulus has written, used only to aim checks at live rules.
    rule_t  stim_rules [2][RULE_SLOTS];
    int     fill_level [2];

    cidr_port_acl_match u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    acl_verdict_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: hold m_tready low for a random stall before each verdict transaction.
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Hold valid across back-to-back transactions; drop it only for a gap.
    task automatic send_item(input acl_req_t rq);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rq.dport, rq.daddr, rq.rprefix, rq.rport, rq.raddr, rq.slot};
        s_tuser  <= {rq.tbl, rq.kind};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Fields the item's kind does not use still carry random values.
    function automatic acl_req_t noise_req();
        acl_req_t rq;
        rq.kind    = req_type_t'($urandom_range(0, 1));
        rq.tbl     = table_sel_t'($urandom_range(0, 1));
        rq.slot    = 8'($urandom);
        rq.raddr   = $urandom;
        rq.rport   = 16'($urandom);
        rq.rprefix = 6'($urandom);
        rq.daddr   = $urandom;
        rq.dport   = 16'($urandom);
        return rq;
    endfunction

    task automatic write_rule(input table_sel_t tbl, input logic [7:0] slot,
                              input logic [31:0] addr, input logic [15:0] port,
                              input logic [5:0] prefix);
        acl_req_t rq;
        rq         = noise_req();
        rq.kind    = REQ_WRITE;
        rq.tbl     = tbl;
        rq.slot    = slot;
        rq.raddr   = addr;
        rq.rport   = port;
        rq.rprefix = prefix;
        stim_rules[tbl][slot] = {addr, port, prefix};
        send_item(rq);
    endtask

    task automatic check_conn(input logic [31:0] addr, input logic [15:0] port);
        acl_req_t rq;
        rq       = noise_req();
        rq.kind  = REQ_CHECK;
        rq.daddr = addr;
        rq.dport = port;
        send_item(rq);
    endtask

    function automatic rule_t random_rule();
        rule_t r;
        r.address = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom);
        r.port    = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        // keep it from acting as a terminator
        if (r.address == '0 && r.port == '0)
            r.port = 16'($urandom_range(1, 65535));
        r.prefix  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
        return r;
    endfunction

    // Destination inside the rule's prefix, with random host bits.
    function automatic logic [31:0] aim_at(input rule_t r);
        logic [31:0] keep;
        if (r.address == '0)
            return $urandom;
        if (r.prefix == '0 || r.prefix >= MAX_PREFIX)
            keep = FULL_MASK;
        else
            keep = FULL_MASK << (32 - r.prefix);
        return (r.address & keep) | (32'($urandom) & ~keep);
    endfunction

    initial begin
        table_sel_t  tbl;
        rule_t       r;
        int          roll;
        int          slot;
        logic [15:0] port;

        foreach (stim_rules[t, i])
            stim_rules[t][i] = '0;
        fill_level[TBL_DENY]  = 0;
        fill_level[TBL_ALLOW] = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty tables: default deny, loopback always passes.
        check_conn(32'h0000_0000, 16'h0000);
        check_conn(LOOPBACK_ADDR, 16'hFFFF);
        write_rule(TBL_DENY, 8'd0, 32'h0A00_0000, 16'd22, 6'd8);
        write_rule(TBL_DENY, 8'd1, 32'hC0A8_0101, 16'd0, 6'd0);
        write_rule(TBL_DENY, 8'd2, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
        write_rule(TBL_DENY, 8'd3, 32'h8000_0000, 16'd0, 6'd1);
        write_rule(TBL_ALLOW, 8'd0, 32'h0000_0000, 16'd443, 6'd17);
        write_rule(TBL_ALLOW, 8'd1, 32'hAC10_0000, 16'd0, 6'd12);
        // beyond the terminator, never reached by a scan
        write_rule(TBL_ALLOW, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 6'd32);
        check_conn(32'h0A12_3456, 16'd22);
        check_conn(32'h0A12_3456, 16'd23);
        check_conn(32'hC0A8_0101, 16'd80);
        check_conn(32'hC0A8_0102, 16'd80);
        check_conn(32'hFFFF_FFFF, 16'hFFFF);
        check_conn(32'h7FFF_FFFE, 16'hFFFF);
        check_conn(32'hDEAD_BEEF, 16'd5);
        check_conn(32'h0102_0304, 16'd443);
        check_conn(32'hAC1F_FFFF, 16'd1);
        check_conn(LOOPBACK_ADDR, 16'd22);
        write_rule(TBL_DENY, 8'd0, 32'h0000_0000, 16'd0, 6'd5);
        check_conn(32'h0A12_3456, 16'd22);
        check_conn(32'h0102_0304, 16'd443);
        fill_level[TBL_DENY]  = 0;
        fill_level[TBL_ALLOW] = 2;
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            roll = $urandom_range(0, 99);
            tbl  = table_sel_t'($urandom_range(0, 1));
            if (roll < 2) begin
                // cut the table short
                slot = $urandom_range(0, (fill_level[tbl] >= RULE_SLOTS) ? RULE_SLOTS - 1
                                                                         : fill_level[tbl]);
                write_rule(tbl, 8'(slot), 32'd0, 16'd0, 6'($urandom));
                fill_level[tbl] = slot;
            end else if (roll < 6) begin
                r = random_rule();
                write_rule(tbl, 8'($urandom_range(0, RULE_SLOTS - 1)),
                           r.address, r.port, r.prefix);
            end else if (roll < 46) begin
                r = random_rule();
                if (fill_level[tbl] < RULE_SLOTS) begin
                    slot = fill_level[tbl];
                    fill_level[tbl]++;
                end else begin
                    slot = $urandom_range(0, RULE_SLOTS - 1);
                end
                write_rule(tbl, 8'(slot), r.address, r.port, r.prefix);
            end else if (roll < 51) begin
                check_conn(LOOPBACK_ADDR, 16'($urandom));
            end else if (roll < 63 || fill_level[tbl] == 0) begin
                check_conn($urandom, 16'($urandom));
            end else begin
                // aim at a live rule, sometimes just off its port
                r    = stim_rules[tbl][$urandom_range(0, fill_level[tbl] - 1)];
                port = (r.port == '0) ? 16'($urandom) : r.port;
                if ($urandom_range(0, 4) == 0)
                    port = port + 16'd1;
                check_conn(aim_at(r), port);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
